[design/vsc_pkg.sv]
// Shared types and constants for the Vigenere stream cipher block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package vsc_pkg;

  // Key storage geometry
  localparam int unsigned KeySlots    = 36;
  localparam int unsigned SlotsPerReg = 12;
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned KeyRegW     = SlotsPerReg * ShiftW;
  localparam int unsigned PosW        = $clog2(KeySlots);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = KeyRegW;

  // Character constants
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [4:0] AlphabetLen = 5'd26;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_FIRST  = 3'd0,
    CFG_KEY_SECOND = 3'd1,
    CFG_KEY_THIRD  = 3'd2,
    CFG_KEY_LENGTH = 3'd3,
    CFG_DECRYPT    = 3'd4
  } cfg_idx_e;

  // Configuration state seen by the datapath
  typedef struct packed {
    logic [3*KeyRegW-1:0] shifts;
    logic [PosW-1:0]      key_len;
    logic                 decrypt;
  } cfg_t;

  // Contents of the input register
  typedef struct packed {
    logic              valid;
    logic [7:0]        data;
    logic              is_space;
    logic [ShiftW-1:0] shift;
    logic              decrypt;
  } stage_t;

endpackage

`default_nettype wire

[design/vsc_cfg_regs.sv]
// Configuration register file of the Vigenere stream cipher block.
// Depends on vsc_pkg for register indexes and the cfg_t struct.
`default_nettype none

module vsc_cfg_regs
  import vsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [KeyRegW-1:0] key_first_q, key_second_q, key_third_q;
  logic [PosW-1:0]    key_len_q;
  logic               decrypt_q;

  // Decode writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
      key_third_q  <= '0;
      key_len_q    <= PosW'(1);
      decrypt_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_FIRST:  key_first_q  <= cfg_data_i[KeyRegW-1:0];
        CFG_KEY_SECOND: key_second_q <= cfg_data_i[KeyRegW-1:0];
        CFG_KEY_THIRD:  key_third_q  <= cfg_data_i[KeyRegW-1:0];
        CFG_KEY_LENGTH: key_len_q    <= cfg_data_i[PosW-1:0];
        CFG_DECRYPT:    decrypt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.shifts  = {key_third_q, key_second_q, key_first_q};
  assign cfg_o.key_len = key_len_q;
  assign cfg_o.decrypt = decrypt_q;

endmodule

`default_nettype wire

[design/vsc_key_stage.sv]
// Key position counter, key shift select and input register.
// Depends on vsc_pkg for cfg_t, stage_t and key geometry.
`default_nettype none

module vsc_key_stage
  import vsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] message_byte_i,
  input  logic       message_start_i,
  input  logic       drain_i,
  output stage_t     stage_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  stage_t            stage_q, stage_d;
  logic [ShiftW-1:0] slots [KeySlots];
  logic [PosW-1:0]   pos_eff, slot_idx, len_eff, pos_adv;
  logic [PosW:0]     pos_inc;
  logic              accept, is_space;

  // Unpack the key registers into slots
  for (genvar k = 0; k < KeySlots; k++) begin : g_slot
    assign slots[k] = cfg_i.shifts[k*ShiftW +: ShiftW];
  end

  // Hold the item while the input register cannot drain
  assign in_stall_o = stage_q.valid & ~drain_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_space   = (message_byte_i == CharSpace);

  // Pick the position and its key shift
  always_comb begin
    pos_eff  = message_start_i ? '0 : pos_q;
    slot_idx = (pos_eff >= PosW'(KeySlots)) ? pos_eff - PosW'(KeySlots) : pos_eff;
    if (cfg_i.key_len == '0) begin
      len_eff = PosW'(1);
    end else if (cfg_i.key_len > PosW'(KeySlots)) begin
      len_eff = PosW'(KeySlots);
    end else begin
      len_eff = cfg_i.key_len;
    end
    pos_inc = {1'b0, pos_eff} + (PosW+1)'(1);
    pos_adv = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[PosW-1:0];
  end

  // Advance the position on non-space items only
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = is_space ? pos_eff : pos_adv;
    end
  end

  // Load or drain the input register
  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      stage_d.valid    = 1'b1;
      stage_d.data     = message_byte_i;
      stage_d.is_space = is_space;
      stage_d.shift    = slots[slot_idx];
      stage_d.decrypt  = cfg_i.decrypt;
    end else if (drain_i) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      stage_q <= '0;
    end else begin
      pos_q   <= pos_d;
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(KeySlots))
    else $error("key position out of range");

  a_space_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_space && !message_start_i |=> $stable(pos_q))
    else $error("space advanced the key position");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && message_start_i && !is_space |=> pos_q <= PosW'(1))
    else $error("message start did not restart the key position");
`endif

endmodule

`default_nettype wire

[design/vsc_out_stage.sv]
// Byte shift with letter wrap, and the result register.
// Depends on vsc_pkg for stage_t and character constants.
`default_nettype none

module vsc_out_stage
  import vsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_t     stage_i,
  output logic       drain_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cipher_byte_o
);

  logic              valid_q, valid_d;
  logic [7:0]        cipher_q, cipher_d;
  logic signed [9:0] sum, lo, hi, fixed;
  logic              upper;

  // Result register can take a new item when empty or being read
  assign drain_o = ~valid_q | ~out_stall_i;

  // Add or subtract the shift, then wrap once by the alphabet length
  always_comb begin
    upper = (stage_i.data >= CharUpperA) && (stage_i.data <= CharUpperZ);
    lo    = upper ? $signed({2'b00, CharUpperA}) : $signed({2'b00, CharLowerA});
    hi    = upper ? $signed({2'b00, CharUpperZ}) : $signed({2'b00, CharLowerZ});
    if (stage_i.decrypt) begin
      sum = $signed({2'b00, stage_i.data}) - $signed({5'b0, stage_i.shift});
    end else begin
      sum = $signed({2'b00, stage_i.data}) + $signed({5'b0, stage_i.shift});
    end
    if (sum < lo) begin
      fixed = sum + $signed({5'b0, AlphabetLen});
    end else if (sum > hi) begin
      fixed = sum - $signed({5'b0, AlphabetLen});
    end else begin
      fixed = sum;
    end
    cipher_d = stage_i.is_space ? stage_i.data : fixed[7:0];
  end

  // Load on drain, drop when taken
  always_comb begin
    valid_d = valid_q;
    if (drain_o) begin
      valid_d = stage_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_o && stage_i.valid) begin
      cipher_q <= cipher_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign cipher_byte_o = cipher_q;

endmodule

`default_nettype wire

[design/vigenere_stream_cipher_top.sv]
// Top level of the Vigenere stream cipher block.
// Depends on vsc_pkg, vsc_cfg_regs, vsc_key_stage and vsc_out_stage.
`default_nettype none

// Accepts one message byte per clock while in_stall_o is low and returns one
// cipher byte for each, in order. A byte is first held in the input register,
// then its result in the result register, from which it is taken: the key
// position counter and the 36-way key shift select work ahead of the input
// register, the add-with-wrap works between the input register and the
// result register. Throughput is one item per cycle while out_stall_i is
// low; with a result waiting, one more item is still taken into the input
// register. No clearing pass after reset. Write configuration only while
// no item is in flight.

module vigenere_stream_cipher_top
  import vsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          message_byte_i,
  input  logic                message_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          cipher_byte_o
);

  cfg_t   cfg;
  stage_t stage;
  logic   drain;

  // Configuration registers
  vsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Key position and input register
  vsc_key_stage u_key (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .message_byte_i  (message_byte_i),
    .message_start_i (message_start_i),
    .drain_i         (drain),
    .stage_o         (stage)
  );

  // Shift and result register
  vsc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .drain_o       (drain),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_byte_o (cipher_byte_o)
  );

endmodule

`default_nettype wire
